// File: design/jbcu_pkg.sv
// Shared types, codes and tables for the JPEG block coefficient unpacker.
// No dependencies; the sequencer, dequantizer and top level import this package.
package jbcu_pkg;

  localparam int DEF_NUM_COMPONENTS = 4;
  localparam int DEF_NUM_QTABLES    = 4;
  localparam int BLOCK_LEN          = 64;
  localparam int QTAB_LEN           = 64;

  localparam logic [1:0] REQ_DC    = 2'd0;
  localparam logic [1:0] REQ_AC    = 2'd1;
  localparam logic [1:0] REQ_QLOAD = 2'd2;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_RUN_CLIP = 2'd1;
  localparam logic [1:0] ERR_NO_BLOCK = 2'd2;
  localparam logic [1:0] ERR_DC_SAT   = 2'd3;

  localparam logic [7:0] SYM_EOB = 8'h00;
  localparam logic [7:0] SYM_ZRL = 8'hF0;
  localparam logic [3:0] NIBBLE  = 4'hF;
  localparam logic [3:0] MAX_CAT = 4'd11;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  component;
    logic [7:0]  symbol;
    logic [10:0] extra_bits;
    logic [1:0]  qtable_id;
    logic [5:0]  qtable_pos;
    logic [7:0]  qtable_value;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] coefficient;
    logic [5:0]         natural_pos;
    logic               last_of_block;
    logic               last_of_item;
    logic [1:0]         error_code;
  } out_item_t;

  // one coefficient request from the sequencer to the dequantizer
  typedef struct packed {
    logic signed [11:0] value;
    logic [5:0]         zz;
    logic               last_of_item;
    logic [1:0]         error_code;
  } issue_t;

  localparam logic [5:0] ZZ_TO_NAT [BLOCK_LEN] = '{
     6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
     6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
     6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
     6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
     6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
     6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
     6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
     6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  // JPEG EXTEND: category above 11 counts as 11
  function automatic logic signed [11:0] jbcu_extend(input logic [10:0] bits,
                                                     input logic [7:0] cat);
    logic [3:0]  c;
    logic [11:0] full;
    logic [11:0] half;
    logic [11:0] v;
    c    = (cat > {4'd0, MAX_CAT}) ? MAX_CAT : cat[3:0];
    full = (12'd1 << c) - 12'd1;
    half = (12'd1 << c) >> 1;
    v    = {1'b0, bits} & full;
    if (c == 4'd0) begin
      return 12'sd0;
    end else if (v < half) begin
      return $signed(v - full);
    end else begin
      return $signed(v);
    end
  endfunction

endpackage

// File: design/jbcu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jbcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/jbcu_seq.sv
// Item sequencer: accepts items, keeps DC predictors and block position, expands
// runs into one coefficient request per cycle while iss_ready is high. Uses jbcu_pkg.
module jbcu_seq #(
  parameter int NUM_COMPONENTS = jbcu_pkg::DEF_NUM_COMPONENTS,
  parameter int NUM_QTABLES    = jbcu_pkg::DEF_NUM_QTABLES,
  parameter int QADDR_W        = $clog2(NUM_QTABLES * jbcu_pkg::QTAB_LEN)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jbcu_pkg::in_item_t in_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  output logic              iss_valid,
  input  logic              iss_ready,
  output jbcu_pkg::issue_t  iss_data,
  output logic              ram_we,
  output logic [QADDR_W-1:0] ram_waddr,
  output logic [7:0]        ram_wdata,
  output logic              ram_re,
  output logic [QADDR_W-1:0] ram_raddr
);
  import jbcu_pkg::*;

  localparam int PRED_IDX_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                state_r, state_nxt;
  logic [7:0]          cfg_r;
  logic signed [11:0]  pred_r [NUM_COMPONENTS];
  logic [6:0]          zz_r, zz_nxt;
  logic                open_r, open_nxt;
  logic [1:0]          cc_r, cc_nxt;
  logic [6:0]          zleft_r, zleft_nxt;
  logic                has_r, has_nxt;
  logic signed [11:0]  val_r, val_nxt;
  logic [1:0]          err_r, err_nxt;

  logic                acc;
  logic                fire;
  logic                comp_ok;
  logic                dc_go;
  logic [PRED_IDX_W-1:0] pidx;
  logic signed [11:0]  dc_ext;
  logic signed [12:0]  dc_sum13;
  logic                dc_sat;
  logic signed [11:0]  dc_sum;
  logic                is_eob;
  logic                is_zrl;
  logic [6:0]          ac_zeros;
  logic                ac_has;
  logic [7:0]          ac_end;
  logic [1:0]          sel_comp;
  logic [1:0]          sel_raw;
  logic [1:0]          sel;
  logic [7:0]          raddr_full;
  logic [7:0]          waddr_full;

  assign in_stall = !(state_r == ST_IDLE && iss_ready);
  assign acc      = in_valid && !in_stall;
  assign fire     = iss_valid && iss_ready;

  assign comp_ok  = {1'b0, in_data.component} < 3'(NUM_COMPONENTS);
  assign dc_go    = acc && in_data.req_type == REQ_DC && comp_ok;
  assign pidx     = in_data.component[PRED_IDX_W-1:0];

  // DC difference, predictor add and 12-bit saturation
  always_comb begin
    dc_ext   = jbcu_extend(in_data.extra_bits, in_data.symbol);
    dc_sum13 = {pred_r[pidx][11], pred_r[pidx]} + {dc_ext[11], dc_ext};
    dc_sat   = dc_sum13[12] ^ dc_sum13[11];
    if (dc_sat) begin
      dc_sum = dc_sum13[12] ? 12'sh800 : 12'sh7FF;
    end else begin
      dc_sum = dc_sum13[11:0];
    end
  end

  // AC run/size decode against the current position
  always_comb begin
    is_eob = in_data.symbol == SYM_EOB;
    is_zrl = in_data.symbol == SYM_ZRL;
    if (is_eob) begin
      ac_zeros = 7'(BLOCK_LEN) - zz_r;
    end else if (is_zrl) begin
      ac_zeros = 7'd16;
    end else begin
      ac_zeros = {3'd0, in_data.symbol[7:4] & NIBBLE};
    end
    ac_has = !is_eob && !is_zrl;
    ac_end = {1'b0, zz_r} + {1'b0, ac_zeros} + {7'd0, ac_has};
  end

  // quantizer table select, clamped to the last table
  always_comb begin
    sel_comp = dc_go ? in_data.component : cc_r;
    sel_raw  = cfg_r[{sel_comp, 1'b0} +: 2];
    sel      = ({1'b0, sel_raw} >= 3'(NUM_QTABLES)) ? 2'(NUM_QTABLES - 1) : sel_raw;
    raddr_full = {sel, (dc_go ? 6'd0 : zz_r[5:0])};
    waddr_full = {in_data.qtable_id, in_data.qtable_pos};
  end

  assign ram_re    = fire;
  assign ram_raddr = raddr_full[QADDR_W-1:0];
  assign ram_we    = acc && in_data.req_type == REQ_QLOAD &&
                     {1'b0, in_data.qtable_id} < 3'(NUM_QTABLES);
  assign ram_waddr = waddr_full[QADDR_W-1:0];
  assign ram_wdata = in_data.qtable_value;

  always_comb begin
    state_nxt = state_r;
    zz_nxt    = zz_r;
    open_nxt  = open_r;
    cc_nxt    = cc_r;
    zleft_nxt = zleft_r;
    has_nxt   = has_r;
    val_nxt   = val_r;
    err_nxt   = err_r;
    iss_valid = 1'b0;
    iss_data  = '{value: 12'sd0, zz: zz_r[5:0], last_of_item: 1'b0, error_code: ERR_OK};

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_data.req_type)
            REQ_DC: begin
              if (comp_ok) begin
                iss_valid = 1'b1;
                iss_data  = '{value: dc_sum, zz: 6'd0, last_of_item: 1'b1,
                              error_code: dc_sat ? ERR_DC_SAT : ERR_OK};
                cc_nxt    = in_data.component;
                open_nxt  = 1'b1;
                zz_nxt    = 7'd1;
              end
            end
            REQ_AC: begin
              if (!open_r) begin
                iss_valid = 1'b1;
                iss_data  = '{value: 12'sd0, zz: 6'd0, last_of_item: 1'b1,
                              error_code: ERR_NO_BLOCK};
              end else begin
                state_nxt = ST_RUN;
                val_nxt   = jbcu_extend(in_data.extra_bits, {4'd0, in_data.symbol[3:0]});
                if (ac_end > 8'(BLOCK_LEN)) begin
                  zleft_nxt = 7'(BLOCK_LEN) - zz_r;
                  has_nxt   = 1'b0;
                  err_nxt   = ERR_RUN_CLIP;
                end else begin
                  zleft_nxt = ac_zeros;
                  has_nxt   = ac_has;
                  err_nxt   = ERR_OK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        iss_valid = 1'b1;
        if (zleft_r != 7'd0) begin
          iss_data.last_of_item = (zleft_r == 7'd1) && !has_r;
        end else begin
          iss_data.value        = val_r;
          iss_data.last_of_item = 1'b1;
        end
        iss_data.error_code = err_r;
        if (fire) begin
          if (zleft_r != 7'd0) begin
            zleft_nxt = zleft_r - 7'd1;
          end else begin
            has_nxt = 1'b0;
          end
          zz_nxt = zz_r + 7'd1;
          if (zz_r == 7'(BLOCK_LEN - 1)) begin
            open_nxt = 1'b0;
          end
          if (iss_data.last_of_item) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cfg_r   <= 8'd0;
      zz_r    <= 7'd0;
      open_r  <= 1'b0;
      cc_r    <= 2'd0;
      zleft_r <= 7'd0;
      has_r   <= 1'b0;
      err_r   <= ERR_OK;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        pred_r[i] <= 12'sd0;
      end
    end else begin
      state_r <= state_nxt;
      zz_r    <= zz_nxt;
      open_r  <= open_nxt;
      cc_r    <= cc_nxt;
      zleft_r <= zleft_nxt;
      has_r   <= has_nxt;
      err_r   <= err_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (dc_go) begin
        pred_r[pidx] <= dc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: design/jbcu_deq.sv
// Dequantizer: aligns a request with its quantizer read, multiplies and
// holds the result in the output register. Uses jbcu_pkg.
module jbcu_deq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              iss_valid,
  output logic              iss_ready,
  input  jbcu_pkg::issue_t  iss_data,
  input  logic [7:0]        q_rdata,
  output logic              out_valid,
  input  logic              out_stall,
  output jbcu_pkg::out_item_t out_data
);
  import jbcu_pkg::*;

  logic               s1_v_r;
  issue_t             s1_r;
  logic               out_v_r;
  out_item_t          out_r;
  logic               out_free;
  logic signed [20:0] prod;

  assign out_free  = !out_v_r || !out_stall;
  assign iss_ready = !s1_v_r || out_free;

  // q_rdata is held by the RAM while stage 1 waits
  assign prod = s1_r.value * $signed({1'b0, q_rdata});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (iss_ready) begin
        s1_v_r <= iss_valid;
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss_ready && iss_valid) begin
      s1_r <= iss_data;
    end
    if (out_free && s1_v_r) begin
      // zero never depends on the table entry
      out_r.coefficient   <= (s1_r.value == 12'sd0) ? 20'sd0 : prod[19:0];
      out_r.natural_pos   <= ZZ_TO_NAT[s1_r.zz];
      out_r.last_of_block <= s1_r.zz == 6'(BLOCK_LEN - 1);
      out_r.last_of_item  <= s1_r.last_of_item;
      out_r.error_code    <= s1_r.error_code;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: design/jpeg_block_coefficient_unpacker_unit.sv
// Top level of the JPEG block coefficient unpacker: sequencer, quantizer
// table RAM and dequantizer. Uses jbcu_pkg, jbcu_seq, jbcu_ram, jbcu_deq.
//
//   port group  dir  handshake          payload
//   in_*        in   in_valid/in_stall  jbcu_pkg::in_item_t
//   out_*       out  out_valid/out_stall jbcu_pkg::out_item_t
//   cfg_*       in   cfg_we             cfg_wdata (table select per component)
//
// An AC item in an open block is decoded, then emits its coefficients
// (1..63) one at a time; DC, table-load and ignored items need no run.
// Each result is registered twice after issue: table RAM read, then multiply.
// The sequencer issues at most one coefficient per cycle, set by the single
// RAM read port. Reset is synchronous; the table RAM is not cleared.
// Output stall backs up through the two stages and then stalls the input.
module jpeg_block_coefficient_unpacker_unit #(
  parameter int NUM_COMPONENTS = jbcu_pkg::DEF_NUM_COMPONENTS,
  parameter int NUM_QTABLES    = jbcu_pkg::DEF_NUM_QTABLES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jbcu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output jbcu_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import jbcu_pkg::*;

  localparam int QDEPTH  = NUM_QTABLES * QTAB_LEN;
  localparam int QADDR_W = $clog2(QDEPTH);

  logic               iss_valid;
  logic               iss_ready;
  issue_t             iss_data;
  logic               ram_we;
  logic [QADDR_W-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [QADDR_W-1:0] ram_raddr;
  logic [7:0]         ram_rdata;

  jbcu_seq #(
    .NUM_COMPONENTS (NUM_COMPONENTS),
    .NUM_QTABLES    (NUM_QTABLES),
    .QADDR_W        (QADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .iss_valid (iss_valid),
    .iss_ready (iss_ready),
    .iss_data  (iss_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  jbcu_ram #(
    .WIDTH (8),
    .DEPTH (QDEPTH)
  ) u_qram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  jbcu_deq u_deq (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss_valid (iss_valid),
    .iss_ready (iss_ready),
    .iss_data  (iss_data),
    .q_rdata   (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: test/jpeg_block_coefficient_unpacker_unit_tb.sv
// Self-checking testbench for jpeg_block_coefficient_unpacker_unit: a behavioral
// unpacker predicts every coefficient, and each output transfer is checked in order.
// Depends on jbcu_pkg and the unpacker RTL only.
`timescale 1ns / 100ps

module jpeg_block_coefficient_unpacker_unit_tb;
  import jbcu_pkg::*;

  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         SETTLE_CYCLES = 10;
  localparam int         DC_MAX        = 2047;
  localparam int         DC_MIN        = -2048;
  localparam int         ZRL_LEN       = 16;
  localparam int         HOLD_CYCLES   = 200;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  jpeg_block_coefficient_unpacker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // unpacker state as the block should hold it
  logic signed [11:0] pred_dc [DEF_NUM_COMPONENTS] = '{default: '0};
  logic [7:0]         qtab [DEF_NUM_QTABLES * QTAB_LEN];
  logic [7:0]         qsel     = 8'd0;
  logic [1:0]         blk_comp = 2'd0;
  logic               blk_open = 1'b0;
  int                 zz_next  = 0;
  int                 zz_nat [BLOCK_LEN];

  out_item_t coefs_due [$];

  int send_idle_pct  = 20;
  int recv_idle_pct  = 75;
  int hold_gen       = 0;
  int hold_len       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int mismatch_count = 0;
  int items_sent     = 0;
  int coefs_checked  = 0;
  int qsel_writes    = 0;

  // zigzag scan: walk the anti-diagonals, alternating direction
  initial begin
    int k;
    k = 0;
    for (int s = 0; s < 15; s++) begin
      for (int j = 0; j < 8; j++) begin
        int row;
        row = (s % 2 == 1) ? j : 7 - j;
        if (s - row >= 0 && s - row < 8) begin
          zz_nat[k] = row * 8 + (s - row);
          k++;
        end
      end
    end
  end

  function automatic int extend_magnitude(logic [10:0] bits, logic [7:0] cat);
    int c;
    int full;
    int v;
    c = (cat > MAX_CAT) ? int'(MAX_CAT) : int'(cat);
    if (c == 0) return 0;
    full = (1 << c) - 1;
    v = int'(bits) & full;
    return (v < (1 << (c - 1))) ? v - full : v;
  endfunction

  function automatic out_item_t dequant_coef(int value, int zz, logic [1:0] err);
    out_item_t c;
    int sel;
    int prod;
    sel = (int'(qsel) >> (2 * int'(blk_comp))) & 3;
    if (sel >= DEF_NUM_QTABLES) sel = DEF_NUM_QTABLES - 1;
    prod = value * int'(qtab[sel * QTAB_LEN + zz]);
    c.coefficient   = prod[19:0];
    c.natural_pos   = 6'(zz_nat[zz]);
    c.last_of_block = (zz == BLOCK_LEN - 1);
    c.last_of_item  = 1'b0;
    c.error_code    = err;
    return c;
  endfunction

  // apply one accepted symbol to the state and queue the coefficients it yields
  task automatic unpack_symbol(in_item_t it);
    int sum;
    int p;
    int zeros;
    int has_coef;
    int value;
    int n;
    logic [1:0] err;
    out_item_t c;
    case (it.req_type)
      REQ_QLOAD: begin
        if (it.qtable_id < DEF_NUM_QTABLES)
          qtab[int'(it.qtable_id) * QTAB_LEN + int'(it.qtable_pos)] = it.qtable_value;
      end
      REQ_DC: begin
        if (it.component < DEF_NUM_COMPONENTS) begin
          sum = int'(pred_dc[it.component]) + extend_magnitude(it.extra_bits, it.symbol);
          err = ERR_OK;
          if (sum > DC_MAX) begin
            sum = DC_MAX;
            err = ERR_DC_SAT;
          end
          if (sum < DC_MIN) begin
            sum = DC_MIN;
            err = ERR_DC_SAT;
          end
          pred_dc[it.component] = 12'(sum);
          blk_comp = it.component;
          blk_open = 1'b1;
          c = dequant_coef(sum, 0, err);
          c.last_of_item = 1'b1;
          coefs_due.push_back(c);
          zz_next = 1;
        end
      end
      REQ_AC: begin
        if (!blk_open) begin
          c = '0;
          c.last_of_item = 1'b1;
          c.error_code   = ERR_NO_BLOCK;
          coefs_due.push_back(c);
        end else begin
          p     = zz_next;
          err   = ERR_OK;
          value = 0;
          if (it.symbol == SYM_EOB) begin
            zeros    = BLOCK_LEN - p;
            has_coef = 0;
          end else if (it.symbol == SYM_ZRL) begin
            zeros    = ZRL_LEN;
            has_coef = 0;
          end else begin
            zeros    = int'(it.symbol[7:4]);
            has_coef = 1;
            value    = extend_magnitude(it.extra_bits, {4'd0, it.symbol[3:0]});
          end
          // run past the block end: zeros up to 63, coefficient dropped
          if (p + zeros + has_coef > BLOCK_LEN) begin
            err      = ERR_RUN_CLIP;
            zeros    = BLOCK_LEN - p;
            has_coef = 0;
          end
          n = zeros + has_coef;
          for (int k = 0; k < n; k++) begin
            c = dequant_coef((has_coef == 1 && k == n - 1) ? value : 0, p, err);
            c.last_of_item = (k == n - 1);
            coefs_due.push_back(c);
            p++;
          end
          zz_next = p;
          if (p >= BLOCK_LEN) blk_open = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch %0d: %s", mismatch_count, msg);
  endtask

  task automatic check_coef(out_item_t got);
    out_item_t want;
    if (coefs_due.size() == 0) begin
      report_mismatch($sformatf("unexpected transfer coef %0d pos %0d",
                                got.coefficient, got.natural_pos));
      return;
    end
    want = coefs_due.pop_front();
    coefs_checked++;
    if (got.coefficient !== want.coefficient)
      report_mismatch($sformatf("coefficient %0d, want %0d (pos %0d)",
                                got.coefficient, want.coefficient, want.natural_pos));
    if (got.natural_pos !== want.natural_pos)
      report_mismatch($sformatf("natural_pos %0d, want %0d", got.natural_pos, want.natural_pos));
    if (got.last_of_block !== want.last_of_block)
      report_mismatch($sformatf("last_of_block %b, want %b (pos %0d)",
                                got.last_of_block, want.last_of_block, want.natural_pos));
    if (got.last_of_item !== want.last_of_item)
      report_mismatch($sformatf("last_of_item %b, want %b (pos %0d)",
                                got.last_of_item, want.last_of_item, want.natural_pos));
    if (got.error_code !== want.error_code)
      report_mismatch($sformatf("error_code %0d, want %0d (pos %0d)",
                                got.error_code, want.error_code, want.natural_pos));
  endtask

  // output side: check each transfer, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_coef(out_data);
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d coefficients outstanding",
               cycle_count, coefs_due.size());
      $display("jpeg_block_coefficient_unpacker_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic in_item_t rand_item();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t sym_item(logic [1:0] kind, logic [1:0] comp,
                                        logic [7:0] sym, logic [10:0] bits);
    in_item_t it;
    it = rand_item();
    it.req_type   = kind;
    it.component  = comp;
    it.symbol     = sym;
    it.extra_bits = bits;
    return it;
  endfunction

  function automatic in_item_t load_item(logic [1:0] id, logic [5:0] pos, logic [7:0] val);
    in_item_t it;
    it = rand_item();
    it.req_type     = REQ_QLOAD;
    it.qtable_id    = id;
    it.qtable_pos   = pos;
    it.qtable_value = val;
    return it;
  endfunction

  // offer one item, hold it until the transfer, then predict its output
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    unpack_symbol(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (coefs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_qsel(logic [7:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    qsel = v;
    qsel_writes++;
  endtask

  task automatic test_no_open_block();
    send_item(sym_item(REQ_AC, 2'd0, 8'h01, 11'd1));
    send_item(sym_item(REQ_UNUSED, 2'd1, 8'h01, 11'd1));
    wait_drained();
  endtask

  // every entry gets written before any coefficient can read it
  task automatic test_qtable_load();
    for (int id = 0; id < DEF_NUM_QTABLES; id++)
      for (int pos = 0; pos < QTAB_LEN; pos++)
        send_item(load_item(2'(id), 6'(pos), 8'($urandom_range(255))));
    send_item(load_item(2'd0, 6'd0, 8'd255));
    send_item(load_item(2'd3, 6'd63, 8'd255));
    send_item(load_item(2'd1, 6'd1, 8'd0));
    wait_drained();
  endtask

  task automatic test_dc_extremes();
    write_qsel(8'h00);
    send_item(sym_item(REQ_DC, 2'd0, 8'd0, 11'h7FF));
    send_item(sym_item(REQ_DC, 2'd1, 8'd11, 11'h7FF));
    send_item(sym_item(REQ_DC, 2'd1, 8'd11, 11'h7FF));   // saturates high
    send_item(sym_item(REQ_DC, 2'd2, 8'd11, 11'h000));
    send_item(sym_item(REQ_DC, 2'd2, 8'd11, 11'h000));   // saturates low
    send_item(sym_item(REQ_DC, 2'd3, 8'd255, 11'h400));  // category clamps to 11
    send_item(sym_item(REQ_DC, 2'd0, 8'd1, 11'h000));
    // new DC abandons the open block
    send_item(sym_item(REQ_AC, 2'd2, 8'h01, 11'd0));
    send_item(sym_item(REQ_DC, 2'd1, 8'd3, 11'd5));
    send_item(sym_item(REQ_AC, 2'd0, SYM_EOB, 11'd0));
    wait_drained();
  endtask

  task automatic test_ac_symbols();
    write_qsel(8'h1B);
    send_item(sym_item(REQ_DC, 2'd3, 8'd2, 11'd3));
    send_item(sym_item(REQ_AC, 2'd0, 8'h01, 11'd1));
    send_item(sym_item(REQ_AC, 2'd1, 8'h0B, 11'd0));
    send_item(sym_item(REQ_AC, 2'd2, 8'h0F, 11'h7FF));  // size clamps to 11
    send_item(sym_item(REQ_AC, 2'd3, SYM_ZRL, 11'h555));
    send_item(sym_item(REQ_AC, 2'd0, 8'h30, 11'h2AA));  // run with zero size
    send_item(sym_item(REQ_AC, 2'd1, 8'h5A, 11'($urandom_range(2047))));
    send_item(sym_item(REQ_AC, 2'd2, SYM_EOB, 11'h7FF));
    send_item(sym_item(REQ_AC, 2'd3, 8'h01, 11'd1));    // block already closed
    wait_drained();
  endtask

  task automatic test_run_clip();
    send_item(sym_item(REQ_DC, 2'd1, 8'd4, 11'd9));
    repeat (3) send_item(sym_item(REQ_AC, 2'd0, SYM_ZRL, 11'd0));
    send_item(sym_item(REQ_AC, 2'd0, 8'hF5, 11'd17));   // coefficient dropped
    send_item(sym_item(REQ_DC, 2'd2, 8'd1, 11'd1));
    repeat (4) send_item(sym_item(REQ_AC, 2'd0, SYM_ZRL, 11'd0));  // last ZRL clipped
    wait_drained();
  endtask

  // long output hold so the pipeline fills and backs up into the input
  task automatic test_output_hold();
    hold_len <= HOLD_CYCLES;
    hold_gen <= hold_gen + 1;
    send_item(sym_item(REQ_DC, 2'd0, 8'd5, 11'd20));
    send_item(sym_item(REQ_AC, 2'd1, SYM_EOB, 11'd0));
    send_item(sym_item(REQ_DC, 2'd1, 8'd6, 11'd40));
    repeat (5) send_item(sym_item(REQ_AC, 2'd2, 8'h13, 11'($urandom_range(2047))));
    send_item(sym_item(REQ_AC, 2'd3, SYM_EOB, 11'd0));
    wait_drained();
  endtask

  function automatic logic [7:0] rand_ac_symbol();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return SYM_ZRL;
    if (pick < 11) return SYM_EOB;
    if (pick < 75) return {4'($urandom_range(3)), 4'($urandom_range(11, 1))};
    return 8'($urandom_range(255));
  endfunction

  // mostly DC + AC run + EOB blocks, with loads and junk mixed in
  task automatic run_random_blocks(int n_items);
    int sent;
    int pick;
    int n_ac;
    logic [7:0] cat;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        cat = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 12)) : 8'($urandom_range(11));
        send_item(sym_item(REQ_DC, 2'($urandom_range(3)), cat, 11'($urandom_range(2047))));
        n_ac = $urandom_range(12);
        repeat (n_ac)
          send_item(sym_item(REQ_AC, 2'($urandom_range(3)), rand_ac_symbol(),
                             11'($urandom_range(2047))));
        sent += n_ac + 1;
        if ($urandom_range(9) < 8) begin
          send_item(sym_item(REQ_AC, 2'($urandom_range(3)), SYM_EOB, 11'($urandom_range(2047))));
          sent++;
        end
      end else if (pick < 88) begin
        send_item(load_item(2'($urandom_range(3)), 6'($urandom_range(63)),
                            8'($urandom_range(255))));
        sent++;
      end else begin
        it = rand_item();
        send_item(it);
        if (it.req_type != REQ_UNUSED) sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    write_qsel(8'hFF);
    run_random_blocks(8);
    send_idle_pct = 75;
    recv_idle_pct = 20;
    write_qsel(8'hE4);
    run_random_blocks(8);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_qsel(8'($urandom_range(255)));
    test_output_hold();
    run_random_blocks(8);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_open_block();
    test_qtable_load();
    test_dc_extremes();
    test_ac_symbols();
    test_run_clip();
    test_random_traffic();
    if (coefs_due.size() != 0)
      report_mismatch($sformatf("%0d coefficients never arrived", coefs_due.size()));
    $display("covered %0d input transfers and %0d coefficient transfers, %0d table-select writes",
             items_sent, coefs_checked, qsel_writes);
    $display("DC saturation, EOB/ZRL, clipped runs, missing blocks and a long output hold");
    if (mismatch_count == 0) begin
      $display("jpeg_block_coefficient_unpacker_unit_tb: PASS");
    end else begin
      $display("jpeg_block_coefficient_unpacker_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
